// ===== rtl/ted_pkg.sv =====
// ----------------------------------------------------------------------------
// ted_pkg: shared types and constants of the text encoding detector
// Verdict codes, the per-sample tracking state and the byte order mark bytes.
// ----------------------------------------------------------------------------
package ted_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ACC_W  = 21;

  // Byte order mark of UTF-8.
  localparam logic [BYTE_W-1:0] BOM_BYTE0 = 8'hEF;
  localparam logic [BYTE_W-1:0] BOM_BYTE1 = 8'hBB;
  localparam logic [BYTE_W-1:0] BOM_BYTE2 = 8'hBF;
  localparam logic [1:0]        BOM_DONE  = 2'd3;

  // Code point limits.
  localparam logic [ACC_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [ACC_W-1:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [ACC_W-1:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [ACC_W-1:0] CP_MIN_LEN2 = 21'h000080;
  localparam logic [ACC_W-1:0] CP_MIN_LEN3 = 21'h000800;
  localparam logic [ACC_W-1:0] CP_MIN_LEN4 = 21'h010000;

  // Sequence lengths.
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  typedef enum logic [1:0] {
    ENC_BOM  = 2'd0,
    ENC_UTF8 = 2'd1,
    ENC_GBK  = 2'd2
  } encoding_t;

  typedef struct packed {
    logic [1:0]       bom_position;
    logic             bom_match;
    logic [2:0]       sequence_length;
    logic [2:0]       bytes_in_sequence;
    logic [ACC_W-1:0] code_accumulator;
    logic             sequence_broken;
    logic             sample_invalid;
  } ted_state_t;

  localparam ted_state_t STATE_RESET = '{
    bom_position:      2'd0,
    bom_match:         1'b1,
    sequence_length:   SEQ_NONE,
    bytes_in_sequence: 3'd0,
    code_accumulator:  '0,
    sequence_broken:   1'b0,
    sample_invalid:    1'b0
  };

  // Expected mark byte at a given position of the sample.
  function automatic logic [BYTE_W-1:0] bom_byte(input logic [1:0] pos);
    logic [BYTE_W-1:0] val;
    case (pos)
      2'd0:    val = BOM_BYTE0;
      2'd1:    val = BOM_BYTE1;
      default: val = BOM_BYTE2;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/ted_step.sv =====
// ----------------------------------------------------------------------------
// ted_step: next-state logic for one byte
// Advances the mark check and the UTF-8 sequence tracker by one byte and
// forms the verdict that the sample would get if this byte were its last.
// ----------------------------------------------------------------------------
module ted_step (
  input  ted_pkg::ted_state_t          cur,
  input  logic [ted_pkg::BYTE_W-1:0]   data_byte,
  output ted_pkg::ted_state_t          nxt,
  output ted_pkg::encoding_t           verdict
);
  import ted_pkg::*;

  // A completed sequence is bad if overlong, a surrogate or out of range.
  function automatic logic completed_bad(input logic [2:0] len,
                                         input logic [ACC_W-1:0] cp);
    logic overlong;
    logic surrogate;
    overlong  = ((len == SEQ_LEN2) && (cp < CP_MIN_LEN2)) ||
                ((len == SEQ_LEN3) && (cp < CP_MIN_LEN3)) ||
                ((len == SEQ_LEN4) && (cp < CP_MIN_LEN4));
    surrogate = (cp >= CP_SURR_LO) && (cp <= CP_SURR_HI);
    return overlong || surrogate || (cp > CP_MAX);
  endfunction

  logic [ACC_W-1:0] acc_shift;
  logic [2:0]       count_inc;
  logic             broken;

  assign acc_shift = {cur.code_accumulator[ACC_W-7:0], data_byte[5:0]};
  assign count_inc = cur.bytes_in_sequence + 3'd1;
  assign broken    = cur.sequence_broken || (data_byte[7:6] != 2'b10);

  always_comb begin
    nxt = cur;

    // Byte order mark check over the first three bytes.
    if (cur.bom_position != BOM_DONE) begin
      if (data_byte != bom_byte(cur.bom_position)) begin
        nxt.bom_match = 1'b0;
      end
      nxt.bom_position = cur.bom_position + 2'd1;
    end

    // Sequence tracking.
    if (cur.sequence_length == SEQ_NONE) begin
      if (!data_byte[7]) begin
        // A single-byte character leaves the tracker idle.
      end else if (data_byte[7:5] == 3'b110) begin
        nxt.sequence_length   = SEQ_LEN2;
        nxt.code_accumulator  = ACC_W'(data_byte[4:0]);
        nxt.bytes_in_sequence = 3'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
        nxt.sequence_length   = SEQ_LEN3;
        nxt.code_accumulator  = ACC_W'(data_byte[3:0]);
        nxt.bytes_in_sequence = 3'd1;
      end else if (data_byte[7:3] == 5'b11110) begin
        nxt.sequence_length   = SEQ_LEN4;
        nxt.code_accumulator  = ACC_W'(data_byte[2:0]);
        nxt.bytes_in_sequence = 3'd1;
      end else begin
        nxt.sample_invalid = 1'b1;
      end
    end else if (count_inc >= cur.sequence_length) begin
      // The sequence completes on this byte and the tracker closes.
      if (broken || completed_bad(cur.sequence_length, acc_shift)) begin
        nxt.sample_invalid = 1'b1;
      end
      nxt.sequence_length   = SEQ_NONE;
      nxt.bytes_in_sequence = 3'd0;
      nxt.code_accumulator  = '0;
      nxt.sequence_broken   = 1'b0;
    end else begin
      nxt.sequence_broken   = broken;
      nxt.code_accumulator  = acc_shift;
      nxt.bytes_in_sequence = count_inc;
    end
  end

  // Verdict as seen after this byte.
  always_comb begin
    if ((nxt.bom_position == BOM_DONE) && nxt.bom_match) begin
      verdict = ENC_BOM;
    end else if (nxt.sample_invalid) begin
      verdict = ENC_GBK;
    end else begin
      verdict = ENC_UTF8;
    end
  end

endmodule

// ===== rtl/text_encoding_detector.sv =====
// ----------------------------------------------------------------------------
// text_encoding_detector: byte-order-mark and UTF-8 check of a text sample
// Top level with the tracking state, the handshakes and the result register.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle, every cycle, whenever the result
// register is empty or its item is taken in the same cycle. Each byte goes
// through one stage of next-state logic into the tracking registers; the byte
// flagged as last also loads the verdict into the result register, which
// presents it in the cycle after that byte is accepted. The tracking state returns
// to its reset value after the last byte, so the next sample may follow at once.
module text_encoding_detector (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ted_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         in_last_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_encoding
);
  import ted_pkg::*;

  ted_state_t state_r;
  ted_state_t state_nxt;
  encoding_t  verdict;
  logic       out_valid_r;
  encoding_t  encoding_r;
  logic       in_fire;

  ted_step u_step (
    .cur       (state_r),
    .data_byte (in_data_byte),
    .nxt       (state_nxt),
    .verdict   (verdict)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Tracking state, cleared after the last byte of each sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_fire) begin
      state_r <= in_last_byte ? STATE_RESET : state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last_byte) begin
      encoding_r <= verdict;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_encoding = encoding_r;

endmodule

// ===== rtl/ted_checker.sv =====
// ----------------------------------------------------------------------------
// ted_checker: port-level assertions for the text encoding detector
// Watches the handshakes and the verdict code over time.
// ----------------------------------------------------------------------------
module ted_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_encoding
);
  import ted_pkg::*;

  // A waiting result item holds its verdict until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_encoding))
    else $error("result item changed while stalled");

  // A presented verdict is always one of the defined codes.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_encoding == ENC_BOM) || (out_encoding == ENC_UTF8) ||
                  (out_encoding == ENC_GBK))
    else $error("undefined verdict code");

  // The last byte of a sample yields a result item in the next cycle.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_byte |=> out_valid)
    else $error("no verdict after last byte");

  // A byte that is not last never creates a result item.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) && !(in_valid && in_ready && in_last_byte) |=> !out_valid)
    else $error("result item without a last byte");

  // Input is ready whenever the result slot is free or being emptied.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free result slot");

endmodule

bind text_encoding_detector ted_checker u_ted_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_last_byte (in_last_byte),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_encoding (out_encoding)
);

// ===== dv/text_encoding_detector_tb.sv =====
// ----------------------------------------------------------------------------
// text_encoding_detector_tb: self-checking bench of the text encoding detector
// Feeds text samples one byte per item, starting with a directed table and
// followed by random samples that are mostly well-formed UTF-8 with some
// broken or noisy ones. A behavioral model predicts each verdict that the table
// does not give; each verdict item is checked in order. The sender pauses
// between bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module text_encoding_detector_tb;
  import ted_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1500;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE       = 10;
  localparam int unsigned NUM_ROWS     = 25;

  // One row of the directed table; want only counts when typed is set.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    encoding_t  want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // Single-byte samples: plain ASCII, bad lead, NUL.
    '{8'h41, 1'b1, 1'b1, ENC_UTF8},
    '{8'hFF, 1'b1, 1'b1, ENC_GBK},
    '{8'h00, 1'b1, 1'b1, ENC_UTF8},
    // Byte order mark alone.
    '{8'hEF, 1'b0, 1'b0, ENC_UTF8},
    '{8'hBB, 1'b0, 1'b0, ENC_UTF8},
    '{8'hBF, 1'b1, 1'b1, ENC_BOM},
    // Short sample that starts like the mark and is cut off.
    '{8'hEF, 1'b0, 1'b0, ENC_UTF8},
    '{8'hBB, 1'b1, 1'b0, ENC_UTF8},
    // Overlong two-byte form.
    '{8'hC0, 1'b0, 1'b0, ENC_UTF8},
    '{8'h80, 1'b1, 1'b1, ENC_GBK},
    // Surrogate.
    '{8'hED, 1'b0, 1'b0, ENC_UTF8},
    '{8'hA0, 1'b0, 1'b0, ENC_UTF8},
    '{8'h80, 1'b1, 1'b1, ENC_GBK},
    // Code point above the Unicode range.
    '{8'hF4, 1'b0, 1'b0, ENC_UTF8},
    '{8'h90, 1'b0, 1'b0, ENC_UTF8},
    '{8'h80, 1'b0, 1'b0, ENC_UTF8},
    '{8'h80, 1'b1, 1'b1, ENC_GBK},
    // Non-continuation byte that completes a sequence.
    '{8'hC3, 1'b0, 1'b0, ENC_UTF8},
    '{8'h41, 1'b1, 1'b0, ENC_UTF8},
    // Non-continuation byte in a sequence that is cut off.
    '{8'hE4, 1'b0, 1'b0, ENC_UTF8},
    '{8'h41, 1'b1, 1'b0, ENC_UTF8},
    // Valid four-byte character.
    '{8'hF0, 1'b0, 1'b0, ENC_UTF8},
    '{8'h9F, 1'b0, 1'b0, ENC_UTF8},
    '{8'h98, 1'b0, 1'b0, ENC_UTF8},
    '{8'h80, 1'b1, 1'b0, ENC_UTF8}
  };

  localparam logic [7:0] MARK_BYTES [3] = '{BOM_BYTE0, BOM_BYTE1, BOM_BYTE2};

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_encoding;

  // Model state of the detector.
  logic [1:0]  mark_pos;
  logic        mark_ok;
  logic [2:0]  open_len;
  logic [2:0]  open_count;
  logic [20:0] cp_acc;
  logic        open_broken;
  logic        text_bad;

  encoding_t   verdict_q [$];
  logic [7:0]  sample_bytes [$];
  int unsigned errors;
  int unsigned cycle_count;
  int unsigned burst_left;

  text_encoding_detector dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_encoding (out_encoding)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (errors < 50) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  // Model state back to its idle value, as after reset or a final byte.
  function automatic void clear_tracking();
    mark_pos    = 2'd0;
    mark_ok     = 1'b1;
    open_len    = SEQ_NONE;
    open_count  = 3'd0;
    cp_acc      = '0;
    open_broken = 1'b0;
    text_bad    = 1'b0;
  endfunction

  // Advances the model by one byte and gives the verdict on a final byte.
  task automatic predict_verdict(input logic [7:0] b, input logic last,
                                 output bit has_res, output encoding_t verdict);
    logic bad_cp;
    has_res = 1'b0;
    verdict = ENC_UTF8;
    // Compare the first three bytes with the byte order mark.
    if (mark_pos < BOM_DONE) begin
      if (b != MARK_BYTES[mark_pos]) mark_ok = 1'b0;
      mark_pos = mark_pos + 2'd1;
    end
    if (open_len == SEQ_NONE) begin
      // Lead byte of a new character.
      if (b[7] == 1'b0) begin
      end else if (b[7:5] == 3'b110) begin
        open_len = SEQ_LEN2; cp_acc = {16'd0, b[4:0]}; open_count = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
        open_len = SEQ_LEN3; cp_acc = {17'd0, b[3:0]}; open_count = 3'd1;
      end else if (b[7:3] == 5'b11110) begin
        open_len = SEQ_LEN4; cp_acc = {18'd0, b[2:0]}; open_count = 3'd1;
      end else begin
        text_bad = 1'b1;
      end
    end else begin
      // Trailing byte; any byte is taken, a wrong one only marks the sequence.
      if (b[7:6] != 2'b10) open_broken = 1'b1;
      cp_acc = {cp_acc[14:0], b[5:0]};
      open_count = open_count + 3'd1;
      if (open_count >= open_len) begin
        bad_cp = (open_len == SEQ_LEN2 && cp_acc < CP_MIN_LEN2) ||
                 (open_len == SEQ_LEN3 && cp_acc < CP_MIN_LEN3) ||
                 (open_len == SEQ_LEN4 && cp_acc < CP_MIN_LEN4) ||
                 (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI) ||
                 (cp_acc > CP_MAX);
        if (open_broken || bad_cp) text_bad = 1'b1;
        open_len    = SEQ_NONE;
        open_count  = 3'd0;
        cp_acc      = '0;
        open_broken = 1'b0;
      end
    end
    if (last) begin
      has_res = 1'b1;
      if (mark_pos == BOM_DONE && mark_ok) verdict = ENC_BOM;
      else if (text_bad) verdict = ENC_GBK;
      else verdict = ENC_UTF8;
      clear_tracking();
    end
  endtask

  // Drives one byte item and waits for its handshake; the sender works in bursts.
  task automatic send_item(input logic [7:0] b, input logic last,
                           input logic typed, input encoding_t want);
    int unsigned gap;
    bit          has_res;
    encoding_t   verdict;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_verdict(b, last, has_res, verdict);
    if (has_res) verdict_q.insert(verdict_q.size(), typed ? want : verdict);
  endtask

  // Holds the sender off until every expected verdict has come.
  task automatic drain_verdicts();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    burst_left = 0;
  endtask

  // Appends one byte to the sample under construction.
  function automatic void add_byte(input logic [7:0] b);
    sample_bytes.insert(sample_bytes.size(), b);
  endfunction

  // Appends a code point encoded in len bytes, overlong or out of range alike.
  function automatic void encode_cp(input logic [20:0] cp, input int len);
    case (len)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Appends one valid character, now and then at the edge of its length class.
  function automatic void add_good_char();
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    int unsigned cp;
    len = $urandom_range(1, 4);
    case (len)
      1:       begin lo = 32'h0;     hi = 32'h7F;     end
      2:       begin lo = 32'h80;    hi = 32'h7FF;    end
      3:       begin lo = 32'h800;   hi = 32'hFFFF;   end
      default: begin lo = 32'h10000; hi = 32'h10FFFF; end
    endcase
    case ($urandom_range(0, 7))
      0:       cp = lo;
      1:       cp = hi;
      default: cp = $urandom_range(lo, hi);
    endcase
    // Steer clear of the surrogate range.
    if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp ^ 32'h1000;
    encode_cp(cp[20:0], len);
  endfunction

  // Appends one invalid construct.
  function automatic void add_bad_char();
    int unsigned len;
    int unsigned cp;
    case ($urandom_range(0, 4))
      0: begin
        // Overlong form.
        len = $urandom_range(2, 4);
        case (len)
          2:       cp = $urandom_range(0, 32'h7F);
          3:       cp = $urandom_range(0, 32'h7FF);
          default: cp = $urandom_range(0, 32'hFFFF);
        endcase
        encode_cp(cp[20:0], len);
      end
      1: begin
        cp = $urandom_range(32'hD800, 32'hDFFF);
        encode_cp(cp[20:0], 3);
      end
      2: begin
        cp = $urandom_range(32'h110000, 32'h1FFFFF);
        encode_cp(cp[20:0], 4);
      end
      3: begin
        // Stray continuation byte or a lead byte that is never valid.
        if ($urandom_range(0, 1) == 0) add_byte(8'($urandom_range(8'h80, 8'hBF)));
        else add_byte(8'($urandom_range(8'hF8, 8'hFF)));
      end
      default: begin
        // Complete sequence whose last byte is not a continuation byte.
        len = $urandom_range(2, 4);
        cp = $urandom_range(32'h800, 32'hCFFF);
        encode_cp(cp[20:0], len);
        void'(sample_bytes.pop_back());
        if ($urandom_range(0, 1) == 0) add_byte(8'($urandom_range(8'h00, 8'h7F)));
        else add_byte(8'($urandom_range(8'hC0, 8'hFF)));
      end
    endcase
  endfunction

  // Builds one random sample into sample_bytes.
  function automatic void build_sample();
    int unsigned kind;
    int unsigned nchar;
    int unsigned bad_at;
    int unsigned pos;
    logic [7:0]  noise;
    sample_bytes.delete();
    kind   = $urandom_range(0, 99);
    nchar  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    bad_at = $urandom_range(0, nchar - 1);
    if (kind >= 80 && kind < 90) begin
      // Pure noise.
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      if (kind < 10) begin
        // Byte order mark, sometimes off by one bit.
        foreach (MARK_BYTES[i]) add_byte(MARK_BYTES[i]);
        if (kind >= 6) begin
          pos = $urandom_range(0, 2);
          sample_bytes[pos] = sample_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        nchar = $urandom_range(0, nchar);
      end
      for (int unsigned i = 0; i < nchar; i++) begin
        if (kind >= 90 && i == bad_at) add_bad_char();
        else add_good_char();
      end
      if (sample_bytes.size() == 0) add_good_char();
      if (kind >= 65 && kind < 80) begin
        // Corrupt the well-formed text: replace, cut short, or insert a byte.
        noise = 8'($urandom_range(0, 255));
        pos   = $urandom_range(0, sample_bytes.size() - 1);
        case ($urandom_range(0, 2))
          0:       sample_bytes[pos] = noise;
          1:       if (sample_bytes.size() > 1) void'(sample_bytes.pop_back());
          default: sample_bytes.insert(pos, noise);
        endcase
      end
    end
  endfunction

  // Receiver: ready pattern switches between open, random, sparse and long stalls.
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned stall_left;
    mode_left  = 0;
    stall_left = 0;
    mode       = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
          end
        end
      endcase
    end
  end

  // Verdict checker.
  always @(posedge clk) begin : verdict_check
    encoding_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with none expected", out_encoding));
      end else begin
        want = verdict_q.pop_front();
        if (out_encoding !== want)
          report_mismatch($sformatf("encoding %0d, expected %0d", out_encoding, want));
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned sent;
    int unsigned samples;
    int unsigned drain_a;
    int unsigned drain_b;
    errors       = 0;
    cycle_count  = 0;
    burst_left   = 0;
    sent         = 0;
    samples      = 0;
    drain_a      = $urandom_range(5, 30);
    drain_b      = $urandom_range(80, 150);
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    clear_tracking();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int unsigned i = 0; i < NUM_ROWS; i++)
      send_item(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);

    // Random samples.
    while (sent < RANDOM_BYTES) begin
      if (samples == drain_a || samples == drain_b) drain_verdicts();
      build_sample();
      foreach (sample_bytes[i]) begin
        send_item(sample_bytes[i], i == sample_bytes.size() - 1, 1'b0, ENC_UTF8);
        sent++;
      end
      samples++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ted_pkg.sv
rtl/ted_step.sv
rtl/text_encoding_detector.sv
rtl/ted_checker.sv
dv/text_encoding_detector_tb.sv
